[hdl/mie_pkg.sv]
// Shared types, constants and the microcode program of the modular inverse unit.
// Used by mie_sequencer, mie_datapath and modular_inverse_euclid_unit.
package mie_pkg;

  localparam int unsigned FIELD_W       = 32;
  localparam int unsigned STATUS_W      = 2;
  localparam int unsigned WIDTH_DEFAULT = 32;
  localparam int unsigned PC_W          = 3;

  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_INVERSE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INPUT  = 2'd2;

  // step addresses of the program
  localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [PC_W-1:0] STEP_TEST  = 3'd2;
  localparam logic [PC_W-1:0] STEP_ALIGN = 3'd3;
  localparam logic [PC_W-1:0] STEP_DBL   = 3'd4;
  localparam logic [PC_W-1:0] STEP_ADD   = 3'd5;
  localparam logic [PC_W-1:0] STEP_UPD   = 3'd6;
  localparam logic [PC_W-1:0] STEP_END   = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_INIT,
    OP_ALIGN,
    OP_DBL,
    OP_ADD,
    OP_UPD,
    OP_FINISH
  } op_e;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_IN,
    C_BAD,
    C_RC_ZERO,
    C_CAN_SHIFT,
    C_K_NZ,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic bad;
    logic rc_zero;
    logic can_shift;
    logic k_nz;
    logic out_busy;
  } dp_status_t;

  // branch to target when cond holds, else fall through to pc + 1
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      STEP_IDLE:  w = '{op: OP_LOAD,   cond: C_NO_IN,     target: STEP_IDLE};
      STEP_CHECK: w = '{op: OP_NOP,    cond: C_BAD,       target: STEP_END};
      STEP_TEST:  w = '{op: OP_INIT,   cond: C_RC_ZERO,   target: STEP_END};
      STEP_ALIGN: w = '{op: OP_ALIGN,  cond: C_CAN_SHIFT, target: STEP_ALIGN};
      STEP_DBL:   w = '{op: OP_DBL,    cond: C_NEVER,     target: STEP_ADD};
      STEP_ADD:   w = '{op: OP_ADD,    cond: C_K_NZ,      target: STEP_DBL};
      STEP_UPD:   w = '{op: OP_UPD,    cond: C_ALWAYS,    target: STEP_TEST};
      STEP_END:   w = '{op: OP_FINISH, cond: C_OUT_BUSY,  target: STEP_END};
      default:    w = '{op: OP_NOP,    cond: C_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

[hdl/mie_sequencer.sv]
// Microcode sequencer: step counter, program fetch and conditional branch.
// Depends on mie_pkg.
module mie_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mie_pkg::dp_status_t status_i,
  output mie_pkg::uword_t     uword_o
);

  logic [mie_pkg::PC_W-1:0] pc_q, pc_d;
  mie_pkg::uword_t          uw;
  logic                     hit;

  assign uw      = mie_pkg::ucode_rom(pc_q);
  assign uword_o = uw;

  always_comb begin
    unique case (uw.cond)
      mie_pkg::C_NEVER:     hit = 1'b0;
      mie_pkg::C_ALWAYS:    hit = 1'b1;
      mie_pkg::C_NO_IN:     hit = !status_i.in_valid;
      mie_pkg::C_BAD:       hit = status_i.bad;
      mie_pkg::C_RC_ZERO:   hit = status_i.rc_zero;
      mie_pkg::C_CAN_SHIFT: hit = status_i.can_shift;
      mie_pkg::C_K_NZ:      hit = status_i.k_nz;
      mie_pkg::C_OUT_BUSY:  hit = status_i.out_busy;
      default:              hit = 1'b1;
    endcase
    pc_d = hit ? uw.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= mie_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[hdl/mie_datapath.sv]
// Datapath of the modular inverse unit: remainder, coefficient and divider
// registers, modular add/double/subtract and the output register. Depends on mie_pkg.
module mie_datapath #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mie_pkg::uword_t               uword_i,
  input  logic                          in_valid_i,
  input  logic [mie_pkg::FIELD_W-1:0]   modulus_i,
  input  logic [mie_pkg::FIELD_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mie_pkg::FIELD_W-1:0]   inverse_o,
  output logic [mie_pkg::STATUS_W-1:0]  status_o,
  output mie_pkg::dp_status_t           status_flags_o
);

  localparam int unsigned DW = (WIDTH < mie_pkg::FIELD_W) ? WIDTH : mie_pkg::FIELD_W;
  localparam int unsigned KW = $clog2(DW);

  logic [DW-1:0] n_q, rp_q, rc_q, tp_q, tc_q, rem_q, dv_q, acc_q;
  logic [KW-1:0] k_q;
  logic          bad_q, bit_q;
  logic          out_valid_q;
  logic [mie_pkg::FIELD_W-1:0]  inverse_q;
  logic [mie_pkg::STATUS_W-1:0] status_q;

  logic [DW-1:0] mod_in, val_in;
  logic          bad_in, can_shift, ge_dv, out_busy, out_load;
  logic [DW:0]   dbl_sum, add_sum;
  logic [DW-1:0] dbl_res, add_res, sub_res;

  assign mod_in = DW'(modulus_i);
  assign val_in = DW'(value_i);
  assign bad_in = (mod_in[DW-1:1] == '0) || (val_in == '0) || (val_in >= mod_in);

  assign can_shift = !dv_q[DW-1] && ({dv_q[DW-2:0], 1'b0} <= rem_q);
  assign ge_dv     = rem_q >= dv_q;

  assign dbl_sum = {acc_q, 1'b0};
  assign dbl_res = (dbl_sum >= {1'b0, n_q}) ? DW'(dbl_sum - {1'b0, n_q}) : DW'(dbl_sum);
  assign add_sum = {1'b0, acc_q} + {1'b0, tc_q};
  assign add_res = (add_sum >= {1'b0, n_q}) ? DW'(add_sum - {1'b0, n_q}) : DW'(add_sum);
  assign sub_res = (tp_q >= acc_q) ? tp_q - acc_q : tp_q - acc_q + n_q;

  assign out_busy = out_valid_q && !out_ready_i;
  assign out_load = (uword_i.op == mie_pkg::OP_FINISH) && !out_busy;

  assign status_flags_o = '{in_valid:  in_valid_i,
                            bad:       bad_q,
                            rc_zero:   (rc_q == '0),
                            can_shift: can_shift,
                            k_nz:      (k_q != '0),
                            out_busy:  out_busy};

  always_ff @(posedge clk_i) begin
    case (uword_i.op)
      mie_pkg::OP_LOAD: begin
        if (in_valid_i) begin
          n_q   <= mod_in;
          rp_q  <= mod_in;
          rc_q  <= val_in;
          tp_q  <= '0;
          tc_q  <= DW'(1);
          bad_q <= bad_in;
        end
      end
      mie_pkg::OP_INIT: begin
        rem_q <= rp_q;
        dv_q  <= rc_q;
        k_q   <= '0;
        acc_q <= '0;
      end
      mie_pkg::OP_ALIGN: begin
        if (can_shift) begin
          dv_q <= {dv_q[DW-2:0], 1'b0};
          k_q  <= k_q + 1'b1;
        end
      end
      mie_pkg::OP_DBL: begin
        acc_q <= dbl_res;
        bit_q <= ge_dv;
        if (ge_dv) rem_q <= rem_q - dv_q;
      end
      mie_pkg::OP_ADD: begin
        if (bit_q) acc_q <= add_res;
        dv_q <= {1'b0, dv_q[DW-1:1]};
        k_q  <= k_q - 1'b1;
      end
      mie_pkg::OP_UPD: begin
        rp_q <= rc_q;
        rc_q <= rem_q;
        tp_q <= tc_q;
        tc_q <= sub_res;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (bad_q) begin
        inverse_q <= '0;
        status_q  <= mie_pkg::STATUS_BAD_INPUT;
      end else if (rp_q != DW'(1)) begin
        inverse_q <= '0;
        status_q  <= mie_pkg::STATUS_NO_INVERSE;
      end else begin
        inverse_q <= mie_pkg::FIELD_W'(tp_q);
        status_q  <= mie_pkg::STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign inverse_o   = inverse_q;
  assign status_o    = status_q;

endmodule

[hdl/modular_inverse_euclid_unit.sv]
// Modular inverse unit, top level: microcode sequencer driving the Euclid datapath.
// Depends on mie_pkg, mie_sequencer and mie_datapath.
//
// Input channel (in_valid_i/in_ready_o) takes one item: modulus_i and value_i.
// Output channel (out_valid_o/out_ready_i) returns one item per input:
// inverse_o and status_o (ok, no inverse, bad input).
// in_ready_o is high only while the sequencer sits at its idle step out of reset.
// Each Euclid step runs one test, the align steps, then for each of the s + 1
// quotient bits a double and an add step, and one update, where s is the bit-length
// gap of the two remainders. A bad input goes from the check step straight to
// the final step. The modular double and the modular add have separate adders.
// The next item is taken only once the sequencer is back at its idle step,
// after the result of the last one has been loaded into the output register.
// The result sits in an output register; the next item is taken while it
// waits. A new result waits at its final step while the receiver stalls.
// Reset puts the sequencer at idle and empties the output register.
module modular_inverse_euclid_unit #(
  parameter int unsigned WIDTH = mie_pkg::WIDTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [mie_pkg::FIELD_W-1:0]   modulus_i,
  input  logic [mie_pkg::FIELD_W-1:0]   value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mie_pkg::FIELD_W-1:0]   inverse_o,
  output logic [mie_pkg::STATUS_W-1:0]  status_o
);

  mie_pkg::uword_t     uword;
  mie_pkg::dp_status_t flags;

  assign in_ready_o = rst_ni && (uword.op == mie_pkg::OP_LOAD);

  mie_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (flags),
    .uword_o  (uword)
  );

  mie_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .uword_i        (uword),
    .in_valid_i     (in_valid_i),
    .modulus_i      (modulus_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inverse_o      (inverse_o),
    .status_o       (status_o),
    .status_flags_o (flags)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != mie_pkg::STATUS_OK) |-> inverse_o == '0)
    else $error("failed result carries a nonzero inverse");

  a_ok_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == mie_pkg::STATUS_OK) |-> inverse_o != '0)
    else $error("zero inverse reported as ok");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == mie_pkg::STATUS_OK) ||
                    (status_o == mie_pkg::STATUS_NO_INVERSE) ||
                    (status_o == mie_pkg::STATUS_BAD_INPUT))
    else $error("undefined status code");

endmodule

[bench/modular_inverse_euclid_unit_tb.sv]
// Testbench for modular_inverse_euclid_unit: directed and random operand pairs,
// each result checked against an extended-Euclid inverse computed in the bench.
// Depends on mie_pkg and the modular_inverse_euclid_unit RTL.
module modular_inverse_euclid_unit_tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [mie_pkg::FIELD_W-1:0]  inverse;
    logic [mie_pkg::STATUS_W-1:0] status;
  } inv_result_t;

  logic                         clk_i;
  logic                         rst_ni = 1'b0;
  logic                         in_valid_i = 1'b0;
  logic                         in_ready_o;
  logic [mie_pkg::FIELD_W-1:0]  modulus_i = '0;
  logic [mie_pkg::FIELD_W-1:0]  value_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i = 1'b0;
  logic [mie_pkg::FIELD_W-1:0]  inverse_o;
  logic [mie_pkg::STATUS_W-1:0] status_o;

  inv_result_t pending_inverses[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          steady = 1'b0;

  modular_inverse_euclid_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .modulus_i   (modulus_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .inverse_o   (inverse_o),
    .status_o    (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic inv_result_t predict_inverse(input logic [mie_pkg::FIELD_W-1:0] n_in,
                                                  input logic [mie_pkg::FIELD_W-1:0] a_in);
    logic [63:0] n, r_old, r_now, r_new, t_old, t_now, t_new, q, p;
    inv_result_t res;
    n = {32'd0, n_in};
    res.inverse = '0;
    if (n_in < 2 || a_in == 0 || a_in >= n_in) begin
      res.status = mie_pkg::STATUS_BAD_INPUT;
      return res;
    end
    r_old = n;
    r_now = {32'd0, a_in};
    t_old = 0;
    t_now = 1;
    while (r_now != 0) begin
      q = r_old / r_now;
      r_new = r_old - q * r_now;
      p = ((q % n) * t_now) % n;
      t_new = (t_old >= p) ? t_old - p : t_old + (n - p);
      r_old = r_now;
      r_now = r_new;
      t_old = t_now;
      t_now = t_new;
    end
    if (r_old != 1) begin
      res.status = mie_pkg::STATUS_NO_INVERSE;
    end else begin
      res.status = mie_pkg::STATUS_OK;
      res.inverse = t_old[mie_pkg::FIELD_W-1:0];
    end
    return res;
  endfunction

  // valid stays high across back-to-back items; lowered only in a gap
  task automatic offer_operands(input logic [mie_pkg::FIELD_W-1:0] n,
                                input logic [mie_pkg::FIELD_W-1:0] a);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    modulus_i <= n;
    value_i <= a;
    do @(posedge clk_i); while (!in_ready_o);
    pending_inverses.push_back(predict_inverse(n, a));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_operands(output logic [mie_pkg::FIELD_W-1:0] n,
                               output logic [mie_pkg::FIELD_W-1:0] a);
    int unsigned kind, g, m;
    logic [mie_pkg::FIELD_W-1:0] t;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      n = $urandom;
      a = $urandom;
      case ($urandom_range(0, 3))
        0: n = $urandom_range(0, 1);
        1: a = '0;
        2: a = n;
        default: if (a < n) begin t = a; a = n; n = t; end
      endcase
    end else if (kind < 18) begin
      g = $urandom_range(2, 1000);
      m = $urandom_range(2, 4_000_000);
      n = g * m;
      a = g * $urandom_range(1, m - 1);
    end else if (kind < 40) begin
      n = $urandom_range(2, 1000);
      a = $urandom_range(1, n - 1);
    end else begin
      n = ($urandom_range(0, 19) == 0) ? 32'hFFFF_FFFF : $urandom_range(2, 32'hFFFF_FFFF);
      a = $urandom_range(1, n - 1);
    end
  endtask

  task automatic test_bad_inputs();
    offer_operands(32'd0, 32'd0);
    offer_operands(32'd1, 32'd0);
    offer_operands(32'd1, 32'd1);
    offer_operands(32'd0, 32'd5);
    offer_operands(32'd2, 32'd0);
    offer_operands(32'd7, 32'd7);
    offer_operands(32'd7, 32'd8);
    offer_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer_operands(32'd5, 32'hFFFF_FFFF);
    offer_operands(32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_special_values();
    offer_operands(32'd2, 32'd1);
    offer_operands(32'hFFFF_FFFF, 32'd1);
    offer_operands(32'd7, 32'd3);
    offer_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    offer_operands(32'hFFFF_FFFB, 32'd2);
    offer_operands(32'hFFFF_FFFB, 32'hFFFF_FFFA);
  endtask

  task automatic test_no_inverse();
    offer_operands(32'd12, 32'd8);
    offer_operands(32'hFFFF_FFFE, 32'h8000_0000);
    offer_operands(32'hFFFF_FFFF, 32'd3);
    offer_operands(32'd100, 32'd50);
  endtask

  task automatic test_long_chains();
    // consecutive Fibonacci numbers give the longest remainder sequence
    offer_operands(32'd2971215073, 32'd1836311903);
    offer_operands(32'h8000_0000, 32'h7FFF_FFFF);
    offer_operands(32'h8000_0001, 32'h5555_5555);
  endtask

  task automatic test_random_mix(input int unsigned count);
    logic [mie_pkg::FIELD_W-1:0] n, a;
    for (int unsigned i = 0; i < count; i++) begin
      steady = (i >= count / 3) && (i < count / 3 + 150);
      if (i == count / 2) wait_drained();
      pick_operands(n, a);
      offer_operands(n, a);
    end
    steady = 1'b0;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk_i) begin
    inv_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: inverse %h status %0d", inverse_o, status_o);
      end else begin
        exp_res = pending_inverses.pop_front();
        if (inverse_o !== exp_res.inverse || status_o !== exp_res.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: inverse %h status %0d, expected inverse %h status %0d",
                     inverse_o, status_o, exp_res.inverse, exp_res.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[modular_inverse_euclid_unit] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_bad_inputs();
    test_special_values();
    test_no_inverse();
    test_long_chains();
    wait_drained();
    test_random_mix(1025);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_inverses.size() == 0) begin
      $display("[modular_inverse_euclid_unit] OK");
    end else begin
      $display("[modular_inverse_euclid_unit] ERROR");
    end
    $finish;
  end

endmodule
